/* design/tfa_pkg.sv */
`timescale 1ns / 1ps
package tfa_pkg;

  localparam int MAX_PIXELS_DEF = 65536;
  localparam int WINDOW_MAX_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 3;
  localparam int DIV_W       = 17;
  localparam int USED_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_AVG_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN_LENGTH      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEW_WEIGHT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUND_ENABLE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_VARIANCE_ENABLE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PIXELS    = 3'd5;

  localparam logic [1:0] MODE_CUMULATIVE  = 2'd0;
  localparam logic [1:0] MODE_WINDOWED    = 2'd1;
  localparam logic [1:0] MODE_EXPONENTIAL = 2'd2;

  localparam logic [5:0]  WIN_LENGTH_RST   = 6'd10;
  localparam logic [15:0] NEW_WEIGHT_RST   = 16'd19661;
  localparam logic [16:0] FRAME_PIXELS_RST = 17'd65536;
  localparam logic [15:0] USED_SAT         = 16'hFFFF;

  typedef struct packed {
    logic [7:0] pixel;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  average;
    logic [23:0] variance;
    logic        end_of_frame;
    logic [15:0] frames_used;
  } out_item_t;

endpackage

/* design/tfa_ram.sv */
`timescale 1ns / 1ps
module tfa_ram #(
  parameter int     WIDTH = 8,
  parameter longint DEPTH = 2
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/temporal_frame_averager.sv */
`timescale 1ns / 1ps
// Per-pixel temporal averager for 8-bit raster video. One pixel is taken per clock when no
// stall holds the input; its result passes through an 8 + FRAC_BITS stage divider. The
// running averages (Q8.FRAC_BITS) and the window ring of past frames sit in two
// single-port-read memories that are read when a pixel is taken and written back when it
// leaves the divider. A pixel whose position is still in that read-to-write span waits for
// the write, so frames with fewer pixels than that span stall on it. A result that waits
// on the output stalls the whole pipeline. The memories are not cleared: after restart the
// first frame is copied in, and no clearing pass runs.
module temporal_frame_averager
  import tfa_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  localparam int     AW     = 8 + FRAC_BITS;
  localparam int     PW     = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
  localparam int     NPW    = $clog2(MAX_PIXELS + 1);
  localparam int     SW     = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
  localparam int     NW     = $clog2(WINDOW_MAX + 1);
  localparam longint WDEPTH = longint'(WINDOW_MAX) * longint'(MAX_PIXELS);
  localparam int     WAW    = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
  localparam int     NST    = 3 + AW;
  localparam logic [AW-1:0] TOP  = AW'(255) << FRAC_BITS;
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [PW-1:0]     pos;
    logic [WAW-1:0]    waddr;
    logic [7:0]        px;
    logic [AW-1:0]     old;
    logic [AW-1:0]     d1;
    logic [AW-1:0]     mag;
    logic [AW+15:0]    prod;
    logic              neg;
    logic              copy;
    logic              winfull;
    logic              expo;
    logic [DIV_W-1:0]  den;
    logic [AW-1:0]     num;
    logic [DIV_W-2:0]  rem;
    logic [AW-1:0]     quo;
    logic              last;
    logic [USED_W-1:0] used;
    logic              varen;
    logic              rnd;
  } pipe_t;

  typedef struct packed {
    logic [7:0]        px;
    logic [7:0]        avg;
    logic [AW-1:0]     d1;
    logic              last;
    logic [USED_W-1:0] used;
    logic              varen;
  } fin_t;

  // configuration
  logic [1:0]  avg_mode;
  logic [5:0]  win_length;
  logic [15:0] new_weight;
  logic        round_enable;
  logic        variance_enable;
  logic [16:0] frame_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_mode        <= MODE_WINDOWED;
      win_length      <= WIN_LENGTH_RST;
      new_weight      <= NEW_WEIGHT_RST;
      round_enable    <= 1'b0;
      variance_enable <= 1'b0;
      frame_pixels    <= FRAME_PIXELS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_AVG_MODE:        avg_mode        <= wr_data[1:0];
        REG_WIN_LENGTH:      win_length      <= wr_data[5:0];
        REG_NEW_WEIGHT:      new_weight      <= wr_data[15:0];
        REG_ROUND_ENABLE:    round_enable    <= wr_data[0];
        REG_VARIANCE_ENABLE: variance_enable <= wr_data[0];
        REG_FRAME_PIXELS:    frame_pixels    <= wr_data[16:0];
        default: ;
      endcase
    end
  end

  // sequencing state
  logic [PW-1:0]     pixel_position;
  logic [USED_W-1:0] frame_total;
  logic [SW-1:0]     ring_slot;
  logic              variance_ready;

  pipe_t            p  [NST];
  pipe_t            pn [NST];
  logic [NST-1:0]   v;
  logic [DIV_W-1:0] trial [AW];
  logic             fits  [AW];
  fin_t             f;
  logic             fv;
  logic             adv;
  logic             accept;
  logic             hazard;

  logic [NPW-1:0]    npix;
  logic [NW-1:0]     nwin;
  logic [PW-1:0]     pos_e;
  logic [PW-1:0]     pos;
  logic [USED_W-1:0] fc_e;
  logic [SW-1:0]     slot_e;
  logic [SW-1:0]     wslot;
  logic              vr_e;
  logic              last;
  logic              is_win;
  logic              winfull;
  logic [DIV_W-1:0]  den;
  logic [USED_W-1:0] used;
  logic [WAW-1:0]    win_addr;

  assign adv = !out_valid || out_ready;

  always_comb begin
    if (frame_pixels == 17'd0) begin
      npix = NPW'(1);
    end else if (32'(frame_pixels) > 32'(MAX_PIXELS)) begin
      npix = NPW'(MAX_PIXELS);
    end else begin
      npix = NPW'(frame_pixels);
    end
    if (win_length == 6'd0) begin
      nwin = NW'(1);
    end else if (32'(win_length) > 32'(WINDOW_MAX)) begin
      nwin = NW'(WINDOW_MAX);
    end else begin
      nwin = NW'(win_length);
    end
    fc_e   = in_data.restart ? '0 : frame_total;
    slot_e = in_data.restart ? '0 : ring_slot;
    vr_e   = in_data.restart ? 1'b0 : variance_ready;
    pos_e  = in_data.restart ? '0 : pixel_position;
    pos    = (32'(pos_e) >= 32'(npix)) ? '0 : pos_e;
    wslot  = (32'(slot_e) < 32'(nwin)) ? slot_e : '0;
    last   = (32'(pos) + 32'd1) >= 32'(npix);
    is_win = (avg_mode != MODE_CUMULATIVE) && (avg_mode != MODE_EXPONENTIAL);
    winfull = is_win && (32'(fc_e) >= 32'(nwin));
    if (avg_mode == MODE_EXPONENTIAL) begin
      den = DIV_W'(1);
    end else if (winfull) begin
      den = DIV_W'(nwin);
    end else begin
      den = DIV_W'(fc_e) + DIV_W'(1);
    end
    if (winfull) begin
      used = USED_W'(nwin);
    end else if (fc_e == USED_SAT) begin
      used = USED_SAT;
    end else begin
      used = fc_e + USED_W'(1);
    end
    win_addr = WAW'(longint'(wslot) * longint'(MAX_PIXELS)) + WAW'(pos);
  end

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < NST; i++) begin
      if (v[i] && p[i].pos == pos) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_ready = adv && !hazard;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      frame_total    <= '0;
      ring_slot      <= '0;
      variance_ready <= 1'b0;
    end else if (accept) begin
      if (last) begin
        pixel_position <= '0;
        frame_total    <= (fc_e == USED_SAT) ? fc_e : fc_e + USED_W'(1);
        ring_slot      <= (32'(wslot) + 32'd1 >= 32'(nwin)) ? '0 : wslot + SW'(1);
        variance_ready <= 1'b1;
      end else begin
        pixel_position <= pos + PW'(1);
        frame_total    <= fc_e;
        ring_slot      <= slot_e;
        variance_ready <= vr_e;
      end
    end
  end

  // memories
  logic [AW-1:0] avg_rdata;
  logic [7:0]    win_rdata;
  logic          avg_we;
  logic [AW-1:0] new_avg;

  assign avg_we = v[NST-1] && adv;

  tfa_ram #(.WIDTH(AW), .DEPTH(longint'(MAX_PIXELS))) u_avg_ram (
    .clk   (clk),
    .we    (avg_we),
    .waddr (p[NST-1].pos),
    .wdata (new_avg),
    .re    (accept),
    .raddr (pos),
    .rdata (avg_rdata)
  );

  tfa_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_win_ram (
    .clk   (clk),
    .we    (avg_we),
    .waddr (p[NST-1].waddr),
    .wdata (p[NST-1].px),
    .re    (accept),
    .raddr (win_addr),
    .rdata (win_rdata)
  );

  // stage 1 differences
  logic [AW-1:0] target;
  logic          neg1;
  logic [AW-1:0] d1;
  logic [7:0]    dw;

  always_comb begin
    target = {p[0].px, FRAC_BITS'(0)};
    neg1   = target < avg_rdata;
    d1     = neg1 ? avg_rdata - target : target - avg_rdata;
    dw     = (p[0].px < win_rdata) ? win_rdata - p[0].px : p[0].px - win_rdata;
  end

  always_comb begin
    // stage 0: item taken, memory read in flight
    pn[0]         = '0;
    pn[0].pos     = pos;
    pn[0].waddr   = win_addr;
    pn[0].px      = in_data.pixel;
    pn[0].copy    = fc_e == '0;
    pn[0].winfull = winfull;
    pn[0].expo    = avg_mode == MODE_EXPONENTIAL;
    pn[0].den     = den;
    pn[0].last    = last;
    pn[0].used    = used;
    pn[0].varen   = variance_enable && vr_e;
    pn[0].rnd     = round_enable;
    // stage 1: differences and exponential product
    pn[1]      = p[0];
    pn[1].old  = avg_rdata;
    pn[1].d1   = d1;
    pn[1].mag  = p[0].winfull ? {dw, FRAC_BITS'(0)} : d1;
    pn[1].neg  = p[0].winfull ? (p[0].px < win_rdata) : neg1;
    pn[1].prod = (AW+16)'(d1) * (AW+16)'(new_weight);
    // stage 2: divider input
    pn[2]      = p[1];
    pn[2].num  = p[1].expo ? p[1].prod[AW+15:16] : p[1].mag;
    pn[2].rem  = '0;
    pn[2].quo  = '0;
    // restoring divider, one quotient bit per stage
    for (int k = 0; k < AW; k++) begin
      trial[k]            = {p[2+k].rem, p[2+k].num[AW-1-k]};
      fits[k]             = trial[k] >= p[2+k].den;
      pn[3+k]             = p[2+k];
      pn[3+k].rem         = fits[k] ? (DIV_W-1)'(trial[k] - p[2+k].den)
                                    : trial[k][DIV_W-2:0];
      pn[3+k].quo[AW-1-k] = fits[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p <= pn;
    end
  end

  // update, clamp and output byte
  logic [AW:0]   sum;
  logic [AW:0]   rounded;
  logic [8:0]    byte_w;
  logic [7:0]    avg_byte;

  always_comb begin
    sum = {1'b0, p[NST-1].old} + {1'b0, p[NST-1].quo};
    if (p[NST-1].copy) begin
      new_avg = {p[NST-1].px, FRAC_BITS'(0)};
    end else if (p[NST-1].neg) begin
      new_avg = (p[NST-1].quo > p[NST-1].old) ? '0 : p[NST-1].old - p[NST-1].quo;
    end else begin
      new_avg = (sum > {1'b0, TOP}) ? TOP : sum[AW-1:0];
    end
    rounded  = {1'b0, new_avg} + (p[NST-1].rnd ? {1'b0, HALF} : '0);
    byte_w   = rounded[AW:FRAC_BITS];
    avg_byte = byte_w[8] ? 8'hFF : byte_w[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (adv) begin
      fv <= v[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f <= '{px: p[NST-1].px, avg: avg_byte, d1: p[NST-1].d1, last: p[NST-1].last,
             used: p[NST-1].used, varen: p[NST-1].varen};
    end
  end

  // variance and output register
  logic [7:0]    d2;
  logic [AW+7:0] vprod;

  always_comb begin
    d2    = (f.px < f.avg) ? f.avg - f.px : f.px - f.avg;
    vprod = (AW+8)'(f.d1) * (AW+8)'(d2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= '{average:      f.avg,
                    variance:     f.varen ? vprod[FRAC_BITS-8 +: 24] : 24'd0,
                    end_of_frame: f.last,
                    frames_used:  f.used};
    end
  end

  a_reset_clears_output: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_frames_used_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.frames_used != 16'd0)
    else $error("zero frame count on output");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    avg_we |-> !(v[0] && p[0].pos == p[NST-1].pos))
    else $error("two transactions in flight on one pixel position");

endmodule
